[rtl/core/bpat_pkg.sv]
// Shared widths, command and status codes, and table entry type for the badge table.
`default_nettype none

package bpat_pkg;

    // Payload field widths
    localparam int CMD_W     = 2;
    localparam int BADGE_W   = 14;
    localparam int CODE_W    = 14;
    localparam int STATUS_W  = 3;
    localparam int ENTRIES_W = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADGE_USED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CODE_USED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRONG_CODE = 3'd5;

    // One table entry as held in memory
    typedef struct packed {
        logic [BADGE_W-1:0] badge;
        logic [CODE_W-1:0]  code;
    } entry_t;

endpackage

`default_nettype wire

[rtl/core/bpat_if.sv]
// Request and response channel interfaces for the badge table.
`default_nettype none

interface bpat_req_if;
    logic                         valid;
    logic                         ready;
    logic [bpat_pkg::CMD_W-1:0]   command;
    logic [bpat_pkg::BADGE_W-1:0] badge_number;
    logic [bpat_pkg::CODE_W-1:0]  secret_code;

    modport source (output valid, output command, output badge_number,
                    output secret_code, input ready);
    modport sink   (input valid, input command, input badge_number,
                    input secret_code, output ready);
endinterface

interface bpat_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bpat_pkg::STATUS_W-1:0]  status;
    logic [bpat_pkg::ENTRIES_W-1:0] entries_in_use;

    modport source (output valid, output status, output entries_in_use, input ready);
    modport sink   (input valid, input status, input entries_in_use, output ready);
endinterface

`default_nettype wire

[rtl/core/badge_pin_access_table.sv]
// Badge and code access table: one memory of entries walked by a serial sequencer.
//
// The table keeps up to TABLE_DEPTH (badge, code) pairs in order in a single
// synchronous memory, plus a count of the entries in use. Each request
// transaction carries one command and gives exactly one response transaction
// with a status and the entry count after the command. Commands are handled
// one at a time: the sequencer streams the entries through the memory read
// port, one entry per cycle with the read data registered, and stops at the
// first hit. A remove keeps streaming past the hit and moves each later entry
// down one slot as its read data arrives. An add to a full table skips the
// walk. The finish state then loads the response register once it is free,
// and the next request is taken in the cycle after that. The response
// register lets the next request be accepted while a result still waits.
// No clearing pass is needed after reset: entries at or beyond the count are
// never read.
`default_nettype none

module badge_pin_access_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bpat_req_if.sink    req,
    bpat_rsp_if.source  rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > bpat_pkg::ENTRIES_W) ? CNT_W : bpat_pkg::ENTRIES_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                addr_reg, addr_next;
    logic                            dvalid_reg, dvalid_next;
    logic [IDX_W-1:0]                didx_reg, didx_next;
    logic [bpat_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [bpat_pkg::BADGE_W-1:0]    badge_reg, badge_next;
    logic [bpat_pkg::CODE_W-1:0]     code_reg, code_next;
    logic [bpat_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic                            out_valid_reg, out_valid_next;
    logic [bpat_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [bpat_pkg::ENTRIES_W-1:0]  out_entries_reg, out_entries_next;

    // Entry memory
    bpat_pkg::entry_t mem [TABLE_DEPTH];
    bpat_pkg::entry_t rdata_reg;
    logic             mem_re;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    bpat_pkg::entry_t mem_wdata;

    logic             issue;
    logic             hit_badge;
    logic             hit_code;
    logic             out_free;
    logic [EXT_W-1:0] count_ext;

    assign issue     = (addr_reg < count_reg);
    assign hit_badge = dvalid_reg && (rdata_reg.badge == badge_reg);
    assign hit_code  = dvalid_reg && (rdata_reg.code == code_reg);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign count_ext = EXT_W'(count_reg);

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.entries_in_use = out_entries_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        addr_next        = addr_reg;
        dvalid_next      = 1'b0;
        didx_next        = didx_reg;
        cmd_next         = cmd_reg;
        badge_next       = badge_reg;
        code_next        = code_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_entries_next = out_entries_reg;
        mem_re           = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[IDX_W-1:0];
        mem_wdata        = '{badge: badge_reg, code: code_reg};

        // Read stream shared by scan and shift
        if ((state_reg == S_SCAN || state_reg == S_SHIFT) && issue)
        begin
            mem_re      = 1'b1;
            dvalid_next = 1'b1;
            didx_next   = addr_reg[IDX_W-1:0];
            addr_next   = addr_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    badge_next = req.badge_number;
                    code_next  = req.secret_code;
                    addr_next  = '0;
                    if (req.command == bpat_pkg::CMD_ADD && count_reg == DEPTH_CNT)
                    begin
                        res_status_next = bpat_pkg::ST_FULL;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit_badge || (cmd_reg == bpat_pkg::CMD_ADD && hit_code))
                begin
                    state_next      = S_FINISH;
                    res_status_next = bpat_pkg::ST_OK;
                    case (cmd_reg)
                        bpat_pkg::CMD_ADD:
                        begin
                            res_status_next = hit_badge ? bpat_pkg::ST_BADGE_USED
                                                        : bpat_pkg::ST_CODE_USED;
                        end
                        bpat_pkg::CMD_REMOVE:
                        begin
                            // later entries arrive behind the hit; move them down
                            state_next = S_SHIFT;
                        end
                        bpat_pkg::CMD_CHANGE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = didx_reg;
                            mem_wdata = '{badge: rdata_reg.badge, code: code_reg};
                        end
                        default:
                        begin
                            res_status_next = hit_code ? bpat_pkg::ST_OK
                                                       : bpat_pkg::ST_WRONG_CODE;
                        end
                    endcase
                end
                else if (!issue && !dvalid_reg)
                begin
                    // walk ended with no hit
                    state_next = S_FINISH;
                    if (cmd_reg == bpat_pkg::CMD_ADD)
                    begin
                        mem_we          = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = bpat_pkg::ST_OK;
                    end
                    else
                    begin
                        res_status_next = bpat_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_SHIFT:
            begin
                if (dvalid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = didx_reg - IDX_W'(1);
                    mem_wdata = rdata_reg;
                end
                else if (!issue)
                begin
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = bpat_pkg::ST_OK;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_entries_next = count_ext[bpat_pkg::ENTRIES_W-1:0];
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        didx_reg        <= didx_next;
        cmd_reg         <= cmd_next;
        badge_reg       <= badge_next;
        code_reg        <= code_next;
        res_status_reg  <= res_status_next;
        out_status_reg  <= out_status_next;
        out_entries_reg <= out_entries_next;
    end

endmodule

`default_nettype wire

[verif/badge_table_checker.sv]
// Transaction monitor, reply predictor and scoreboard for the badge access table.
`timescale 1ns / 1ps

module badge_table_checker #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic clk,
    input  logic rst_n,
    bpat_req_if  req,
    bpat_rsp_if  rsp,
    output int   fail_count,
    output int   replies_pending,
    output int   replies_checked,
    output int   peak_entries
);

    // One reply as the block should give it
    typedef struct packed {
        logic [bpat_pkg::STATUS_W-1:0]  status;
        logic [bpat_pkg::ENTRIES_W-1:0] entries;
    } reply_t;

    // Shadow of the table contents
    logic [bpat_pkg::BADGE_W-1:0] badge_tbl [TABLE_DEPTH];
    logic [bpat_pkg::CODE_W-1:0]  code_tbl  [TABLE_DEPTH];
    int                           entry_cnt;

    reply_t replies_due [$];

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // Apply one command to the shadow table and work out its reply
    function automatic reply_t apply_badge_command(logic [bpat_pkg::CMD_W-1:0]   cmd,
                                                   logic [bpat_pkg::BADGE_W-1:0] badge,
                                                   logic [bpat_pkg::CODE_W-1:0]  code);
        reply_t r;
        int     hit;
        r.status = bpat_pkg::ST_OK;
        hit = -1;
        if (cmd == bpat_pkg::CMD_ADD)
        begin
            if (entry_cnt >= TABLE_DEPTH)
            begin
                r.status = bpat_pkg::ST_FULL;
            end
            else
            begin
                // badge is compared before code within each entry; first hit wins
                for (int i = 0; i < entry_cnt && r.status == bpat_pkg::ST_OK; i++)
                begin
                    if (badge_tbl[i] == badge)
                        r.status = bpat_pkg::ST_BADGE_USED;
                    else if (code_tbl[i] == code)
                        r.status = bpat_pkg::ST_CODE_USED;
                end
                if (r.status == bpat_pkg::ST_OK)
                begin
                    badge_tbl[entry_cnt] = badge;
                    code_tbl[entry_cnt]  = code;
                    entry_cnt++;
                end
            end
        end
        else
        begin
            for (int i = 0; i < entry_cnt && hit < 0; i++)
            begin
                if (badge_tbl[i] == badge)
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = bpat_pkg::ST_NOT_FOUND;
            end
            else
            begin
                case (cmd)
                    bpat_pkg::CMD_REMOVE:
                    begin
                        // later entries move down by one
                        for (int i = hit; i + 1 < entry_cnt; i++)
                        begin
                            badge_tbl[i] = badge_tbl[i + 1];
                            code_tbl[i]  = code_tbl[i + 1];
                        end
                        entry_cnt--;
                    end
                    bpat_pkg::CMD_CHANGE: code_tbl[hit] = code;
                    default:
                    begin
                        if (code_tbl[hit] != code)
                            r.status = bpat_pkg::ST_WRONG_CODE;
                    end
                endcase
            end
        end
        r.entries = bpat_pkg::ENTRIES_W'(entry_cnt);
        return r;
    endfunction

    // Predict on accepted requests, compare on accepted replies
    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            entry_cnt       = 0;
            replies_due.delete();
            fail_count      = 0;
            replies_pending = 0;
            replies_checked = 0;
            peak_entries    = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                replies_due.push_back(apply_badge_command(req.command, req.badge_number,
                                                          req.secret_code));
                if (entry_cnt > peak_entries)
                    peak_entries = entry_cnt;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch($sformatf("reply with nothing due: status %0d entries %0d",
                                              rsp.status, rsp.entries_in_use));
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.entries_in_use !== want.entries)
                        report_mismatch($sformatf("entries_in_use %0d, expected %0d",
                                                  rsp.entries_in_use, want.entries));
                    replies_checked++;
                end
            end
            replies_pending = replies_due.size();
        end
    end

endmodule

[verif/testbench.sv]
// Top of the badge access table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 2 * TABLE_DEPTH + 10;

    logic clk;
    logic rst_n;
    int   cycle_count = 0;

    bpat_req_if req_ch ();
    bpat_rsp_if rsp_ch ();

    int fail_count;
    int replies_pending;
    int replies_checked;
    int peak_entries;

    // Stimulus control
    bit idle_req;
    bit idle_rsp;
    bit long_hold_req;
    int sent_count;
    int directed_count;

    // Loose memory of what was sent, used only to steer random stimulus
    logic [bpat_pkg::BADGE_W-1:0] known_badges [$];
    logic [bpat_pkg::CODE_W-1:0]  code_of [logic [bpat_pkg::BADGE_W-1:0]];

    badge_pin_access_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    badge_table_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .fail_count(fail_count),
        .replies_pending(replies_pending),
        .replies_checked(replies_checked),
        .peak_entries(peak_entries)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies still due",
                     cycle_count, replies_pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Reply side: random stalls per transaction, plus one long hold on request
    initial
    begin : reply_side
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b1;
            end
            else if (rsp_ch.ready && rsp_ch.valid)
            begin
                gap = idle_rsp ? $urandom_range(0, 16) : 0;
                if (gap > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    rsp_ch.ready <= 1'b1;
                end
            end
            else if (!rsp_ch.ready)
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one command and wait for its acceptance; entered and left at a rising edge
    task automatic send_command(logic [bpat_pkg::CMD_W-1:0]   cmd,
                                logic [bpat_pkg::BADGE_W-1:0] badge,
                                logic [bpat_pkg::CODE_W-1:0]  code);
        int gap;
        gap = idle_req ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.badge_number <= badge;
        req_ch.secret_code  <= code;
        do @(posedge clk); while (!req_ch.ready);
        sent_count++;
        // keep the steering memory roughly in step
        if (cmd == bpat_pkg::CMD_ADD && !code_of.exists(badge))
        begin
            known_badges.push_back(badge);
            code_of[badge] = code;
        end
        else if (cmd == bpat_pkg::CMD_CHANGE && code_of.exists(badge))
        begin
            code_of[badge] = code;
        end
        else if (cmd == bpat_pkg::CMD_REMOVE && code_of.exists(badge))
        begin
            code_of.delete(badge);
            foreach (known_badges[i])
            begin
                if (known_badges[i] == badge)
                begin
                    known_badges.delete(i);
                    break;
                end
            end
        end
    endtask

    // Random command, mostly aimed at badges and codes the table is likely to hold
    task automatic send_random(int add_pct, int remove_pct);
        int                           pick;
        bit                           reuse;
        logic [bpat_pkg::CMD_W-1:0]   cmd;
        logic [bpat_pkg::BADGE_W-1:0] badge;
        logic [bpat_pkg::CODE_W-1:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < add_pct)
            cmd = bpat_pkg::CMD_ADD;
        else if (pick < add_pct + remove_pct)
            cmd = bpat_pkg::CMD_REMOVE;
        else if ($urandom_range(0, 2) == 0)
            cmd = bpat_pkg::CMD_CHANGE;
        else
            cmd = bpat_pkg::CMD_CHECK;
        // adds mostly bring fresh badges, other commands mostly hit known ones
        if (cmd == bpat_pkg::CMD_ADD)
            reuse = known_badges.size() > 0 && $urandom_range(0, 7) == 0;
        else
            reuse = known_badges.size() > 0 && $urandom_range(0, 3) != 0;
        if (reuse)
            badge = known_badges[$urandom_range(0, known_badges.size() - 1)];
        else if ($urandom_range(0, 1) == 1)
            badge = bpat_pkg::BADGE_W'($urandom_range(0, 9999));
        else
            badge = bpat_pkg::BADGE_W'($urandom_range(0, 16383));
        if ($urandom_range(0, 1) == 1)
            code = bpat_pkg::CODE_W'($urandom_range(0, 9999));
        else
            code = bpat_pkg::CODE_W'($urandom_range(0, 16383));
        if (cmd == bpat_pkg::CMD_CHECK && code_of.exists(badge) && $urandom_range(0, 9) < 7)
            code = code_of[badge];
        if (cmd == bpat_pkg::CMD_ADD && known_badges.size() > 0 && $urandom_range(0, 9) == 0)
            code = code_of[known_badges[$urandom_range(0, known_badges.size() - 1)]];
        send_command(cmd, badge, code);
    endtask

    // Stop offering until every reply has come back
    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (replies_pending != 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        rst_n               = 1'b0;
        sent_count          = 0;
        idle_req            = 1'b1;
        idle_rsp            = 1'b1;
        long_hold_req       = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.command      <= bpat_pkg::CMD_ADD;
        req_ch.badge_number <= '0;
        req_ch.secret_code  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, field extremes, ordering of badge and code hits
        send_command(bpat_pkg::CMD_CHECK, 14'd0, 14'd0);           // not found, empty table
        send_command(bpat_pkg::CMD_REMOVE, 14'd0, 14'd0);
        send_command(bpat_pkg::CMD_CHANGE, 14'd16383, 14'd16383);
        send_command(bpat_pkg::CMD_ADD, 14'd0, 14'd0);
        send_command(bpat_pkg::CMD_ADD, 14'd16383, 14'd16383);     // out-of-range stored as is
        send_command(bpat_pkg::CMD_ADD, 14'd0, 14'd5);             // badge used
        send_command(bpat_pkg::CMD_ADD, 14'd7, 14'd16383);         // code used on second entry
        send_command(bpat_pkg::CMD_ADD, 14'd16383, 14'd0);         // earlier code beats badge
        send_command(bpat_pkg::CMD_CHECK, 14'd16383, 14'd16383);   // granted
        send_command(bpat_pkg::CMD_CHECK, 14'd16383, 14'd1);       // wrong code
        send_command(bpat_pkg::CMD_CHANGE, 14'd16383, 14'd0);      // duplicate code allowed
        send_command(bpat_pkg::CMD_CHECK, 14'd16383, 14'd0);
        send_command(bpat_pkg::CMD_ADD, 14'd9999, 14'd9999);
        send_command(bpat_pkg::CMD_REMOVE, 14'd0, 14'd9999);       // first out, rest shift down
        send_command(bpat_pkg::CMD_CHECK, 14'd9999, 14'd9999);
        send_command(bpat_pkg::CMD_REMOVE, 14'd9999, 14'd0);       // last entry out
        send_command(bpat_pkg::CMD_REMOVE, 14'd0, 14'd0);          // already gone
        send_command(bpat_pkg::CMD_ADD, 14'd5000, 14'd0);          // code used
        send_command(bpat_pkg::CMD_ADD, 14'd16383, 14'd0);         // badge checked before code
        send_command(bpat_pkg::CMD_CHECK, 14'd16383, 14'd16383);
        directed_count = sent_count;
        wait_for_replies();

        // Random mix, with a stretch of back-to-back traffic in the middle
        for (int i = 0; i < 160; i++)
        begin
            idle_req = !(i >= 60 && i < 100);
            idle_rsp = idle_req;
            send_random(40, 15);
        end
        idle_req = 1'b1;
        idle_rsp = 1'b1;
        wait_for_replies();

        // Fill to capacity while replies are held back, so the request side stalls
        idle_req      = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 135; i++)
            send_command(bpat_pkg::CMD_ADD, bpat_pkg::BADGE_W'(10000 + i),
                         bpat_pkg::CODE_W'(12000 + i));
        idle_req = 1'b1;

        // Full table: adds report full, lookups that miss walk the whole table
        for (int i = 0; i < 60; i++)
            send_random(30, 0);

        // Drain the table with removes
        for (int i = 0; i < 80; i++)
            send_random(10, 60);

        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d commands sent (%0d directed), %0d replies checked",
                 sent_count, directed_count, replies_checked);
        $display("Summary: table peaked at %0d of %0d entries, one reply hold of %0d cycles",
                 peak_entries, TABLE_DEPTH, LONG_HOLD);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
